// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the adjacency store modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/abms_pkg.sv =====
// ----------------------------------------------------------------------------
// abms_pkg
// Types and constants for the adjacency bit matrix store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package abms_pkg;

  // default number of vertices the matrix holds
  localparam int MAX_VERTICES_DEF = 64;

  // at most this many results per query run
  localparam int RESULT_CAP = 64;
  localparam int HIT_W      = $clog2(RESULT_CAP + 1);

  // vertex count register
  localparam int               VCOUNT_W     = 7;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_ADD_EDGE = 2'd0,
    OP_SUCC     = 2'd1,
    OP_PRED     = 2'd2
  } opcode_e;

  // command kinds after classification
  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_SUCC  = 2'd1,
    KIND_PRED  = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SUCC_RD,
    ST_SUCC_LD,
    ST_PRED_RD,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] src_vertex;
    logic [6:0] dst_vertex;
    logic [6:0] query_vertex;
  } req_t;

  typedef struct packed {
    logic [5:0] neighbour;
    logic       is_last;
    logic       is_empty;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/abms_front.sv =====
// ----------------------------------------------------------------------------
// abms_front
// Holds the vertex count, accepts items and classifies them into commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module abms_front #(
  parameter int MAX_VERTICES = abms_pkg::MAX_VERTICES_DEF,
  localparam int IdxW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int CntW = $clog2(MAX_VERTICES + 1)
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [abms_pkg::VCOUNT_W-1:0]       cfg_wdata_i,
  input  wire                                 start_i,
  input  abms_pkg::req_t                      req_i,
  input  wire                                 q_full_i,
  output logic                                busy_o,
  output logic                                push_o,
  output abms_pkg::kind_e                     kind_o,
  output logic [IdxW-1:0]                     row_o,
  output logic [IdxW-1:0]                     col_o,
  output logic [CntW-1:0]                     cnt_o
);

  logic [abms_pkg::VCOUNT_W-1:0] vcount_q;
  logic [CntW-1:0]               live_cnt;
  logic                          src_ok;
  logic                          dst_ok;
  logic                          qry_ok;
  logic                          accept;

  // vertex count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= abms_pkg::VCOUNT_RESET;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  // effective count, limited to the matrix size
  assign live_cnt = (32'(vcount_q) < 32'(MAX_VERTICES)) ? CntW'(vcount_q)
                                                        : CntW'(MAX_VERTICES);

  assign src_ok = 32'(req_i.src_vertex) < 32'(live_cnt);
  assign dst_ok = 32'(req_i.dst_vertex) < 32'(live_cnt);
  assign qry_ok = 32'(req_i.query_vertex) < 32'(live_cnt);

  assign busy_o = q_full_i;
  assign accept = start_i && !busy_o;
  assign cnt_o  = live_cnt;

  // classify: drop rejected adds and unused opcodes, flag invalid queries
  always_comb begin
    push_o = 1'b0;
    kind_o = abms_pkg::KIND_EMPTY;
    row_o  = IdxW'(req_i.query_vertex);
    col_o  = IdxW'(req_i.query_vertex);
    case (req_i.opcode)
      abms_pkg::OP_ADD_EDGE: begin
        push_o = accept && src_ok && dst_ok;
        kind_o = abms_pkg::KIND_ADD;
        row_o  = IdxW'(req_i.src_vertex);
        col_o  = IdxW'(req_i.dst_vertex);
      end
      abms_pkg::OP_SUCC: begin
        push_o = accept;
        kind_o = qry_ok ? abms_pkg::KIND_SUCC : abms_pkg::KIND_EMPTY;
      end
      abms_pkg::OP_PRED: begin
        push_o = accept;
        kind_o = qry_ok ? abms_pkg::KIND_PRED : abms_pkg::KIND_EMPTY;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/abms_queue.sv =====
// ----------------------------------------------------------------------------
// abms_queue
// Small command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module abms_queue #(
  parameter int Width = 8,
  parameter int Depth = abms_pkg::QUEUE_DEPTH,
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int CntW = $clog2(Depth + 1)
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire  [Width-1:0] data_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  logic [Width-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // the front never pushes into a full queue, the back never pops an empty one
  `ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, push_i, !full_o)
  `ASSERT_IMPL(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o)

endmodule

`default_nettype wire

// ===== hw/rtl/abms_back.sv =====
// ----------------------------------------------------------------------------
// abms_back
// Executes commands against the adjacency matrix and emits neighbour lists.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module abms_back #(
  parameter int MAX_VERTICES = abms_pkg::MAX_VERTICES_DEF,
  localparam int IdxW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int CntW = $clog2(MAX_VERTICES + 1)
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 q_empty_i,
  output logic                pop_o,
  input  abms_pkg::kind_e     kind_i,
  input  wire  [IdxW-1:0]     row_i,
  input  wire  [IdxW-1:0]     col_i,
  input  wire  [CntW-1:0]     cnt_i,
  output logic                res_valid_o,
  output abms_pkg::res_t      res_o
);

  localparam int               HitW   = abms_pkg::HIT_W;
  localparam logic [HitW-1:0]  HitCap = HitW'(abms_pkg::RESULT_CAP);

  // matrix rows, one valid bit per row stands in for the reset clear
  logic [MAX_VERTICES-1:0] mem_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid_q;
  logic [MAX_VERTICES-1:0] rdata_q;
  logic                    rvalid_q;
  logic [MAX_VERTICES-1:0] row_eff;

  logic                    rd_en;
  logic [IdxW-1:0]         rd_addr;
  logic                    wr_en;
  logic [MAX_VERTICES-1:0] wr_data;

  abms_pkg::state_e        state_q, state_d;
  logic                    pred_q, pred_d;
  logic [IdxW-1:0]         row_q, row_d;
  logic [IdxW-1:0]         col_q, col_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CntW-1:0]         scan_idx_q, scan_idx_d;
  logic [MAX_VERTICES-1:0] shift_q, shift_d;
  logic                    chk_v_q, chk_v_d;
  logic [IdxW-1:0]         chk_idx_q, chk_idx_d;
  logic                    pend_v_q, pend_v_d;
  logic [IdxW-1:0]         pend_idx_q, pend_idx_d;
  logic [HitW-1:0]         hit_cnt_q, hit_cnt_d;
  logic                    res_valid_q, res_valid_d;
  abms_pkg::res_t          res_q, res_d;

  logic                    cand_v;
  logic [IdxW-1:0]         cand_idx;
  logic                    cand_bit;

  // row memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[row_q] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_q[row_q] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_q <= row_valid_q[rd_addr];
      end
    end
  end

  assign row_eff = rvalid_q ? rdata_q : '0;

  // current scan candidate: shifted row bit or a freshly read row
  assign cand_v   = pred_q ? chk_v_q : (scan_idx_q < cnt_q);
  assign cand_idx = pred_q ? chk_idx_q : IdxW'(scan_idx_q);
  assign cand_bit = pred_q ? row_eff[col_q] : shift_q[0];

  // state register and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abms_pkg::ST_IDLE;
      pend_v_q    <= 1'b0;
      chk_v_q     <= 1'b0;
      hit_cnt_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_v_q    <= pend_v_d;
      chk_v_q     <= chk_v_d;
      hit_cnt_q   <= hit_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pred_q     <= pred_d;
    row_q      <= row_d;
    col_q      <= col_d;
    cnt_q      <= cnt_d;
    scan_idx_q <= scan_idx_d;
    shift_q    <= shift_d;
    chk_idx_q  <= chk_idx_d;
    pend_idx_q <= pend_idx_d;
    res_q      <= res_d;
  end

  // next state, memory control and result generation
  always_comb begin
    state_d     = state_q;
    pred_d      = pred_q;
    row_d       = row_q;
    col_d       = col_q;
    cnt_d       = cnt_q;
    scan_idx_d  = scan_idx_q;
    shift_d     = shift_q;
    chk_v_d     = 1'b0;
    chk_idx_d   = chk_idx_q;
    pend_v_d    = pend_v_q;
    pend_idx_d  = pend_idx_q;
    hit_cnt_d   = hit_cnt_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = row_q;
    wr_en       = 1'b0;
    wr_data     = row_eff | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << col_q);

    // predecessor scan issues one row read per cycle
    if ((state_q == abms_pkg::ST_PRED_RD) ||
        ((state_q == abms_pkg::ST_SCAN) && pred_q)) begin
      if (scan_idx_q < cnt_q) begin
        rd_en      = 1'b1;
        rd_addr    = IdxW'(scan_idx_q);
        chk_v_d    = 1'b1;
        chk_idx_d  = IdxW'(scan_idx_q);
        scan_idx_d = scan_idx_q + CntW'(1);
      end
    end

    case (state_q)
      abms_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o      = 1'b1;
          row_d      = row_i;
          col_d      = col_i;
          cnt_d      = cnt_i;
          scan_idx_d = '0;
          hit_cnt_d  = '0;
          pend_v_d   = 1'b0;
          case (kind_i)
            abms_pkg::KIND_ADD: begin
              state_d = abms_pkg::ST_ADD_RD;
            end
            abms_pkg::KIND_SUCC: begin
              pred_d  = 1'b0;
              state_d = abms_pkg::ST_SUCC_RD;
            end
            abms_pkg::KIND_PRED: begin
              pred_d  = 1'b1;
              state_d = abms_pkg::ST_PRED_RD;
            end
            default: begin
              res_valid_d    = 1'b1;
              res_d.neighbour = '0;
              res_d.is_last  = 1'b1;
              res_d.is_empty = 1'b1;
            end
          endcase
        end
      end
      abms_pkg::ST_ADD_RD: begin
        rd_en   = 1'b1;
        rd_addr = row_q;
        state_d = abms_pkg::ST_ADD_WR;
      end
      abms_pkg::ST_ADD_WR: begin
        wr_en   = 1'b1;
        state_d = abms_pkg::ST_IDLE;
      end
      abms_pkg::ST_SUCC_RD: begin
        rd_en   = 1'b1;
        rd_addr = row_q;
        state_d = abms_pkg::ST_SUCC_LD;
      end
      abms_pkg::ST_SUCC_LD: begin
        shift_d = row_eff;
        state_d = abms_pkg::ST_SCAN;
      end
      abms_pkg::ST_PRED_RD: begin
        state_d = abms_pkg::ST_SCAN;
      end
      abms_pkg::ST_SCAN: begin
        if (!cand_v || (hit_cnt_q == HitCap)) begin
          // end of run: flush the held hit as last, or report empty
          res_valid_d    = 1'b1;
          res_d.neighbour = pend_v_q ? 6'(pend_idx_q) : 6'd0;
          res_d.is_last  = 1'b1;
          res_d.is_empty = !pend_v_q;
          pend_v_d       = 1'b0;
          state_d        = abms_pkg::ST_IDLE;
        end else begin
          // a new hit releases the previous one, which is not last
          if (cand_bit) begin
            if (pend_v_q) begin
              res_valid_d    = 1'b1;
              res_d.neighbour = 6'(pend_idx_q);
              res_d.is_last  = 1'b0;
              res_d.is_empty = 1'b0;
            end
            pend_v_d   = 1'b1;
            pend_idx_d = cand_idx;
            hit_cnt_d  = hit_cnt_q + HitW'(1);
          end
          if (!pred_q) begin
            shift_d    = shift_q >> 1;
            scan_idx_d = scan_idx_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = abms_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // an empty result always closes its run
  `ASSERT_IMPL(a_empty_is_last, clk_i, rst_ni, res_valid_q && res_q.is_empty, res_q.is_last)
  // the hit count never passes the result cap
  `ASSERT_IMPL(a_hit_cap, clk_i, rst_ni, 1'b1, hit_cnt_q <= HitCap)
  // a held hit exists only while a scan is running
  `ASSERT_IMPL(a_pend_in_scan, clk_i, rst_ni, pend_v_q, state_q == abms_pkg::ST_SCAN)
  // an edge write completes the add and the back returns to idle
  `ASSERT_NEXT(a_add_done, clk_i, rst_ni, wr_en, state_q == abms_pkg::ST_IDLE)

endmodule

`default_nettype wire

// ===== hw/rtl/adjacency_bit_matrix_store.sv =====
// ----------------------------------------------------------------------------
// adjacency_bit_matrix_store
// Directed graph kept as a bit matrix with add-edge and neighbour queries.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low; busy_o rises only
// when the two-entry command queue is full. Results appear for one cycle each
// on res_o with res_valid_o and cannot be held off. The back end owns the row
// memory (one read and one write port), takes a command only from idle, and
// sets the rate: an add reads and rewrites one row, an invalid query gives a
// single empty result, and a query scans up to n row bits or rows, where n is
// the effective vertex count; one row bit or one row is checked per cycle, and
// each hit is emitted when the next one is found, the last when the scan ends.
// Reset clears the graph at once through a valid bit per row, with no clearing
// pass. The vertex count is written through cfg_we_i/cfg_wdata_i; the user must
// do so only while the block is idle, as the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module adjacency_bit_matrix_store #(
  parameter int MAX_VERTICES = abms_pkg::MAX_VERTICES_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [abms_pkg::VCOUNT_W-1:0]  cfg_wdata_i,
  input  wire                            start_i,
  input  abms_pkg::req_t                 req_i,
  output logic                           busy_o,
  output logic                           res_valid_o,
  output abms_pkg::res_t                 res_o
);

  localparam int IdxW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CntW = $clog2(MAX_VERTICES + 1);
  localparam int CmdW = 2 + 2 * IdxW + CntW;

  logic                  push;
  abms_pkg::kind_e       f_kind;
  logic [IdxW-1:0]       f_row;
  logic [IdxW-1:0]       f_col;
  logic [CntW-1:0]       f_cnt;
  logic                  q_full;
  logic                  q_empty;
  logic                  pop;
  logic [CmdW-1:0]       q_wdata;
  logic [CmdW-1:0]       q_rdata;
  abms_pkg::kind_e       b_kind;
  logic [IdxW-1:0]       b_row;
  logic [IdxW-1:0]       b_col;
  logic [CntW-1:0]       b_cnt;

  // front: config register and classification
  abms_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .req_i       (req_i),
    .q_full_i    (q_full),
    .busy_o      (busy_o),
    .push_o      (push),
    .kind_o      (f_kind),
    .row_o       (f_row),
    .col_o       (f_col),
    .cnt_o       (f_cnt)
  );

  // command packing across the queue
  assign q_wdata = {f_kind, f_row, f_col, f_cnt};
  assign b_kind  = abms_pkg::kind_e'(q_rdata[CmdW-1 -: 2]);
  assign b_row   = q_rdata[CntW + 2*IdxW - 1 -: IdxW];
  assign b_col   = q_rdata[CntW + IdxW - 1 -: IdxW];
  assign b_cnt   = q_rdata[CntW-1:0];

  abms_queue #(
    .Width (CmdW),
    .Depth (abms_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // back: matrix memory and scan engine
  abms_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .kind_i      (b_kind),
    .row_i       (b_row),
    .col_i       (b_col),
    .cnt_i       (b_cnt),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
